/* rtl/bcsq_pkg.sv */
// Package with the codes, widths and defaults of the button click and scroll qualifier.
`timescale 1ns / 1ps

package bcsq_pkg;

    localparam int BUTTON_COUNT_DEFAULT = 4;
    localparam int TICK_W               = 32;
    localparam int COUNT_W              = 16;
    localparam int DELTA_W              = COUNT_W + 1;
    localparam int BUTTON_W             = 5;
    localparam int MASK_W               = 32;

    localparam logic [TICK_W-1:0] COOLDOWN_RESET = 32'd1000;

    typedef logic [1:0] action_t;
    typedef logic [1:0] kind_t;

    localparam action_t ACT_PRESS   = 2'd0;
    localparam action_t ACT_RELEASE = 2'd1;
    localparam action_t ACT_SAMPLE  = 2'd2;

    localparam kind_t KIND_NONE   = 2'd0;
    localparam kind_t KIND_CLICK  = 2'd1;
    localparam kind_t KIND_SCROLL = 2'd2;

endpackage

/* rtl/button_click_scroll_qualifier.sv */
// Top level of the button click and scroll qualifier: input register, qualify logic, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// --------  ---------  --------------------  ---------------------------------------------
// in        sink       in_valid / in_stall   action, button, now_tick, encoder_count
// out       source     out_valid / out_stall event_kind, click_button, scroll_delta,
//                                            pressed_mask
// cfg       sink       cfg_valid / cfg_ready cfg_data (cooldown_ticks)
//
// Every input transaction gives exactly one result transaction, through the input register, the
// qualify logic and the result register. One transaction can be accepted each cycle while
// in_stall is low; the rate is set by the single pass of qualify logic between the two registers.
// Reset clears the held and rotated bits, the last count, every release tick and the
// valid flags, and loads the cooldown with its default. A stalled output holds its result
// while the input register can still take one more transaction.

module button_click_scroll_qualifier #(
    parameter int BUTTON_COUNT = bcsq_pkg::BUTTON_COUNT_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  bcsq_pkg::action_t                       action,
    input  logic [bcsq_pkg::BUTTON_W-1:0]           button,
    input  logic [bcsq_pkg::TICK_W-1:0]             now_tick,
    input  logic signed [bcsq_pkg::COUNT_W-1:0]     encoder_count,

    output logic                                    out_valid,
    input  logic                                    out_stall,
    output bcsq_pkg::kind_t                         event_kind,
    output logic [bcsq_pkg::BUTTON_W-1:0]           click_button,
    output logic signed [bcsq_pkg::DELTA_W-1:0]     scroll_delta,
    output logic [bcsq_pkg::MASK_W-1:0]             pressed_mask,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [bcsq_pkg::TICK_W-1:0]             cfg_data
);

    import bcsq_pkg::*;

    // Index width into the per-button tick store; at least one bit so a single
    // button still has a legal index.
    localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    // Configuration register. The user is to write it only while the block is idle; the
    // block itself does not enforce this, and the write is always taken.
    logic [TICK_W-1:0] cooldown_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg <= COOLDOWN_RESET;
        end
        else if (cfg_valid)
        begin
            cooldown_reg <= cfg_data;
        end
    end

    // Input register stage.
    logic                       s1_valid_reg;
    action_t                    s1_action_reg;
    logic [BUTTON_W-1:0]        s1_button_reg;
    logic [TICK_W-1:0]          s1_tick_reg;
    logic signed [COUNT_W-1:0]  s1_count_reg;

    logic out_valid_reg;
    logic advance;
    logic in_accept;
    logic fire;

    // The result register moves when it is empty or its transaction is taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign fire      = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_button_reg <= button;
            s1_tick_reg   <= now_tick;
            s1_count_reg  <= encoder_count;
        end
    end

    // Button state.
    logic [BUTTON_COUNT-1:0]   held_reg;
    logic [BUTTON_COUNT-1:0]   held_next;
    logic [BUTTON_COUNT-1:0]   rotated_reg;
    logic [BUTTON_COUNT-1:0]   rotated_next;
    logic [TICK_W-1:0]         release_tick_reg [BUTTON_COUNT];
    logic signed [COUNT_W-1:0] last_count_reg;
    logic signed [COUNT_W-1:0] last_count_next;

    // Qualify logic for the transaction in the input register.
    logic                      in_range;
    logic [IDX_W-1:0]          idx;
    logic [BUTTON_COUNT-1:0]   sel;
    logic [TICK_W-1:0]         since_release;
    logic                      cooled;
    logic                      record_release;
    kind_t                     kind_next;
    logic [BUTTON_W-1:0]       click_next;
    logic signed [DELTA_W-1:0] delta_next;

    assign in_range      = {1'b0, s1_button_reg} < (BUTTON_W + 1)'(BUTTON_COUNT);
    assign idx           = s1_button_reg[IDX_W-1:0];
    assign sel           = in_range ? (BUTTON_COUNT'(1) << idx) : '0;
    assign since_release = s1_tick_reg - (in_range ? release_tick_reg[idx] : '0);
    assign cooled        = since_release > cooldown_reg;

    always_comb
    begin
        held_next       = held_reg;
        rotated_next    = rotated_reg;
        last_count_next = last_count_reg;
        record_release  = 1'b0;
        kind_next       = KIND_NONE;
        click_next      = '0;
        delta_next      = '0;
        case (s1_action_reg)
            ACT_PRESS:
            begin
                held_next = held_reg | sel;
            end
            ACT_RELEASE:
            begin
                if (in_range)
                begin
                    // A click needs a clean press and enough time since the last release.
                    if (((held_reg & sel) != '0) && ((rotated_reg & sel) == '0) && cooled)
                    begin
                        kind_next  = KIND_CLICK;
                        click_next = s1_button_reg;
                    end
                    record_release = 1'b1;
                    held_next      = held_reg & ~sel;
                    rotated_next   = rotated_reg & ~sel;
                end
            end
            ACT_SAMPLE:
            begin
                if (s1_count_reg != last_count_reg)
                begin
                    // Every button held during a turn of the wheel loses its click.
                    rotated_next = rotated_reg | held_reg;
                    kind_next    = KIND_SCROLL;
                    delta_next   = {last_count_reg[COUNT_W-1], last_count_reg}
                                 - {s1_count_reg[COUNT_W-1], s1_count_reg};
                end
                last_count_next = s1_count_reg;
            end
            default:
            begin
                kind_next = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            rotated_reg    <= '0;
            last_count_reg <= '0;
        end
        else if (fire)
        begin
            held_reg       <= held_next;
            rotated_reg    <= rotated_next;
            last_count_reg <= last_count_next;
        end
    end

    // The release tick store is small and cleared at once by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                release_tick_reg[i] <= '0;
            end
        end
        else if (fire && record_release)
        begin
            release_tick_reg[idx] <= s1_tick_reg;
        end
    end

    // Result register.
    kind_t                     kind_reg;
    logic [BUTTON_W-1:0]       click_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [MASK_W-1:0]         mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg  <= kind_next;
            click_reg <= click_next;
            delta_reg <= delta_next;
            mask_reg  <= MASK_W'(held_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign click_button  = click_reg;
    assign scroll_delta  = delta_reg;
    assign pressed_mask  = mask_reg;

endmodule

/* bench/button_click_scroll_qualifier_tb.sv */
// Self-checking testbench for the button click and scroll qualifier.
`timescale 1ns / 1ps

module button_click_scroll_qualifier_tb;

    import bcsq_pkg::*;

    localparam int BUTTONS = BUTTON_COUNT_DEFAULT;

    // The action code that the block defines no behavior for.
    localparam action_t ACT_UNUSED = 2'd3;

    // One input transaction as the driver presents it.
    typedef struct packed {
        action_t             act;
        logic [BUTTON_W-1:0] btn;
        logic [TICK_W-1:0]   tick;
        logic [COUNT_W-1:0]  count;
    } pointer_event_t;

    // One qualified result as the block should report it.
    typedef struct packed {
        kind_t               kind;
        logic [BUTTON_W-1:0] btn;
        logic [DELTA_W-1:0]  delta;
        logic [MASK_W-1:0]   mask;
    } qualified_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_stall;
    action_t                    action = ACT_PRESS;
    logic [BUTTON_W-1:0]        button = '0;
    logic [TICK_W-1:0]          now_tick = '0;
    logic signed [COUNT_W-1:0]  encoder_count = '0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    kind_t                      event_kind;
    logic [BUTTON_W-1:0]        click_button;
    logic signed [DELTA_W-1:0]  scroll_delta;
    logic [MASK_W-1:0]          pressed_mask;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [TICK_W-1:0]          cfg_data = '0;

    button_click_scroll_qualifier #(
        .BUTTON_COUNT(BUTTONS)
    ) u_top (.*);

    // Stimulus waits in pending_events until the driver presents it; every accepted
    // transaction leaves its predicted result in expected_results for the monitor.
    pointer_event_t pending_events[$];
    qualified_t     expected_results[$];

    int errors = 0;
    int items_made = 0;

    // When quiet is set neither side inserts idle cycles, which gives back-to-back stretches.
    bit quiet = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    logic in_taken = 1'b0;
    pointer_event_t drive_ev;

    // Predictor state, mirroring what the block holds after reset.
    logic [TICK_W-1:0]  cooldown_reg = COOLDOWN_RESET;
    logic [MASK_W-1:0]  held_mask = '0;
    logic [MASK_W-1:0]  rotated_mask = '0;
    logic [TICK_W-1:0]  release_tick [BUTTONS] = '{default: '0};
    logic [COUNT_W-1:0] prev_count = '0;

    // Stimulus bookkeeping, used only to aim release ticks at the cooldown boundary and to
    // keep encoder samples close to the previous count.
    logic [TICK_W-1:0]  plan_cooldown = COOLDOWN_RESET;
    logic [TICK_W-1:0]  plan_release [BUTTONS] = '{default: '0};
    logic [COUNT_W-1:0] plan_count = '0;
    logic [TICK_W-1:0]  tick_now = '0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Applies one input transaction to the predictor state and returns the result that the
    // block must give for it.
    function automatic qualified_t qualify_event(input pointer_event_t ev);
        qualified_t         res;
        logic [MASK_W-1:0]  bit_sel;
        logic [TICK_W-1:0]  elapsed;
        res = '{kind: KIND_NONE, btn: '0, delta: '0, mask: '0};
        case (ev.act)
            ACT_PRESS: begin
                if (ev.btn < BUTTONS)
                    held_mask |= MASK_W'(1) << ev.btn;
            end
            ACT_RELEASE: begin
                if (ev.btn < BUTTONS) begin
                    bit_sel = MASK_W'(1) << ev.btn;
                    // The tick difference wraps, so a release just after the counter rolls
                    // over still measures the true distance.
                    elapsed = ev.tick - release_tick[ev.btn];
                    if ((held_mask & bit_sel) != '0 && (rotated_mask & bit_sel) == '0
                            && elapsed > cooldown_reg) begin
                        res.kind = KIND_CLICK;
                        res.btn  = ev.btn;
                    end
                    release_tick[ev.btn] = ev.tick;
                    held_mask    &= ~bit_sel;
                    rotated_mask &= ~bit_sel;
                end
            end
            ACT_SAMPLE: begin
                if (ev.count != prev_count) begin
                    // Sign-extend both counts; the 17-bit difference cannot overflow.
                    res.kind  = KIND_SCROLL;
                    res.delta = {prev_count[COUNT_W-1], prev_count}
                              - {ev.count[COUNT_W-1], ev.count};
                    rotated_mask |= held_mask;
                end
                prev_count = ev.count;
            end
            default: ;
        endcase
        res.mask = held_mask;
        return res;
    endfunction

    // Most idle runs are short, a few are long, and none happen in quiet stretches.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic void report_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Input side: a transaction is taken at a rising edge with valid high and stall low.
    // The prediction is made right there, so the expected results stay in input order.
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_results.push_back(qualify_event('{act: action, btn: button,
                                                       tick: now_tick, count: encoder_count}));
    end

    // Driver: holds a stalled transaction unchanged, otherwise idles for the gap that was
    // drawn when the previous one was presented, then presents the next pending one.
    always @(negedge clk) begin
        if (rst_n && !(in_valid && !in_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_events.size() != 0) begin
                drive_ev = pending_events.pop_front();
                action        <= drive_ev.act;
                button        <= drive_ev.btn;
                now_tick      <= drive_ev.tick;
                encoder_count <= drive_ev.count;
                in_valid      <= 1'b1;
                gap_left = pick_idle();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure in runs of random length.
    always @(negedge clk) begin
        if (stall_left == 0)
            stall_left = pick_idle();
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    // Monitor: every result taken from the block is checked against the oldest expectation.
    always @(posedge clk) begin
        qualified_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_failure($sformatf("result with nothing expected: kind %0d mask %h",
                                         event_kind, pressed_mask));
            end
            else begin
                want = expected_results.pop_front();
                if (event_kind !== want.kind)
                    report_failure($sformatf("event_kind: expected %0d, got %0d",
                                             want.kind, event_kind));
                if (click_button !== want.btn)
                    report_failure($sformatf("click_button: expected %0d, got %0d",
                                             want.btn, click_button));
                if (scroll_delta !== want.delta)
                    report_failure($sformatf("scroll_delta: expected %0d, got %0d",
                                             $signed(want.delta), scroll_delta));
                if (pressed_mask !== want.mask)
                    report_failure($sformatf("pressed_mask: expected %h, got %h",
                                             want.mask, pressed_mask));
            end
        end
    end

    // Queues one input transaction and records what the generator needs to shape later ones.
    task automatic push_item(input action_t act, input int btn, input logic [TICK_W-1:0] tick,
                             input logic [COUNT_W-1:0] count);
        pending_events.push_back('{act: act, btn: BUTTON_W'(btn), tick: tick, count: count});
        items_made++;
        if (act == ACT_RELEASE && btn < BUTTONS)
            plan_release[btn] = tick;
        if (act == ACT_SAMPLE)
            plan_count = count;
    endtask

    // Waits until every queued transaction has gone in and every result has come out, then
    // lets the pipeline settle.
    task automatic drain();
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The cooldown is only written with the block idle; the predictor takes the new value
    // at the edge where the write goes through.
    task automatic write_cooldown(input logic [TICK_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cooldown_reg  = value;
        plan_cooldown = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A sample near the previous count, now and then anywhere in the full range.
    task automatic push_sample();
        int step;
        step = $urandom_range(6) - 3;
        tick_now += $urandom_range(30);
        if ($urandom_range(7) == 0)
            push_item(ACT_SAMPLE, $urandom_range(31), tick_now, COUNT_W'($urandom));
        else
            push_item(ACT_SAMPLE, $urandom_range(31), tick_now, plan_count + COUNT_W'(step));
    endtask

    // Press, a few things in between, release. The release tick lands on, just past, or
    // well past the cooldown, or just short of it.
    task automatic click_gesture();
        int b;
        int extra;
        logic [TICK_W-1:0] margin;
        b = $urandom_range(BUTTONS - 1);
        tick_now += $urandom_range(200);
        push_item(ACT_PRESS, b, tick_now, COUNT_W'($urandom));
        extra = $urandom_range(2);
        repeat (extra) begin
            tick_now += $urandom_range(50);
            case ($urandom_range(5))
                0, 1:    push_item(ACT_PRESS, $urandom_range(BUTTONS - 1), tick_now,
                                   COUNT_W'($urandom));
                2, 3:    push_item(ACT_SAMPLE, $urandom_range(31), tick_now, plan_count);
                4:       push_sample();
                default: push_item(ACT_RELEASE, $urandom_range(31, BUTTONS), tick_now,
                                   COUNT_W'($urandom));
            endcase
        end
        case ($urandom_range(4))
            0:       margin = 0;
            1:       margin = 1;
            2:       margin = $urandom_range(20);
            3:       margin = $urandom_range(100000);
            default: margin = -TICK_W'($urandom_range(50, 1));
        endcase
        tick_now = plan_release[b] + plan_cooldown + margin;
        push_item(ACT_RELEASE, b, tick_now, COUNT_W'($urandom));
    endtask

    // A run of encoder samples, sometimes with a button held throughout.
    task automatic scroll_gesture();
        int  h;
        bit  hold;
        hold = 1'($urandom_range(1));
        h = $urandom_range(BUTTONS - 1);
        if (hold) begin
            tick_now += $urandom_range(100);
            push_item(ACT_PRESS, h, tick_now, COUNT_W'($urandom));
        end
        repeat ($urandom_range(6, 1))
            push_sample();
        if (hold) begin
            tick_now = plan_release[h] + plan_cooldown + $urandom_range(100, 1);
            push_item(ACT_RELEASE, h, tick_now, COUNT_W'($urandom));
        end
    endtask

    task automatic random_phase(input int n);
        int target;
        int r;
        target = items_made + n;
        while (items_made < target) begin
            // Keep the queue short so that quiet stretches and drains fall at varied points.
            while (pending_events.size() > 6)
                @(posedge clk);
            if ($urandom_range(9) == 0)
                quiet = !quiet;
            if ($urandom_range(39) == 0)
                drain();
            r = $urandom_range(9);
            if (r < 5)
                click_gesture();
            else if (r < 8)
                scroll_gesture();
            else
                repeat ($urandom_range(3, 1))
                    push_item(action_t'($urandom_range(3)), $urandom_range(31), $urandom,
                              COUNT_W'($urandom));
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the cooldown at its reset value of 1000.
        // A release exactly at the cooldown does not click; one tick later does.
        push_item(ACT_PRESS,   0, 32'd5,    16'd0);
        push_item(ACT_RELEASE, 0, 32'd1000, 16'd0);
        push_item(ACT_PRESS,   0, 32'd1500, 16'd0);
        push_item(ACT_RELEASE, 0, 32'd2001, 16'd0);
        // Release of a button that was never pressed still records its tick.
        push_item(ACT_RELEASE, 1, 32'd5000, 16'd0);
        // A repeated press leaves the button held, and the later release clicks.
        push_item(ACT_PRESS,   1, 32'd5100, 16'd0);
        push_item(ACT_PRESS,   1, 32'd5200, 16'd0);
        push_item(ACT_RELEASE, 1, 32'd6001, 16'd0);
        // Scrolling while a button is held takes away its click.
        push_item(ACT_PRESS,   2, 32'd7000, 16'd0);
        push_item(ACT_SAMPLE,  0, 32'd7100, 16'h7FFF);
        push_item(ACT_RELEASE, 2, 32'd100000, 16'd0);
        // An unchanged count gives nothing; then the largest deltas of both signs.
        push_item(ACT_SAMPLE,  0, 32'd100100, 16'h7FFF);
        push_item(ACT_SAMPLE,  0, 32'd100200, 16'h8000);
        push_item(ACT_SAMPLE,  0, 32'd100300, 16'h7FFF);
        // Buttons past the configured count and the unused action change nothing.
        push_item(ACT_PRESS,   31, 32'hFFFF_FFFF, 16'hFFFF);
        push_item(ACT_RELEASE, BUTTONS, 32'd100400, 16'd0);
        push_item(ACT_PRESS,   BUTTONS, 32'd100500, 16'd0);
        push_item(ACT_UNUSED,  0, 32'd100600, 16'h1234);
        // Release ticks across the wrap of the tick counter.
        push_item(ACT_PRESS,   3, 32'hFFFF_FE00, 16'd0);
        push_item(ACT_RELEASE, 3, 32'hFFFF_FF00, 16'd0);
        push_item(ACT_PRESS,   3, 32'h0000_0010, 16'd0);
        push_item(ACT_RELEASE, 3, 32'h0000_02F0, 16'd0);
        push_item(ACT_SAMPLE,  0, 32'h0000_0300, 16'd0);
        tick_now = 32'h0000_0400;
        drain();

        // Random part over several cooldown settings, the extremes among them.
        write_cooldown(32'd0);
        random_phase(170);
        drain();
        write_cooldown(32'hFFFF_FFFF);
        random_phase(130);
        drain();
        write_cooldown(32'd37);
        random_phase(170);
        drain();
        write_cooldown($urandom_range(5000, 1));
        random_phase(170);
        drain();
        write_cooldown(COOLDOWN_RESET);
        random_phase(170);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Safety net far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
